### hdl/sspt_pkg.sv
`timescale 1ns / 1ps
// Package for the pan/tilt smoothstep servo trajectory block.
// Shared widths, defaults, register indexes and the sequencer state type.
package sspt_pkg;

	localparam int ANGLE_W             = 13;
	localparam int SPEED_W             = 10;
	localparam int TIME_W              = 32;
	localparam int CFG_W               = 13;
	localparam int CFG_IDX_W           = 3;
	localparam int ANGLE_FRAC_BITS_DEF = 4;
	localparam int DUTY_BITS_DEF       = 14;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_LO    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_HI    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LO  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_HI  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEF_SPEED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 3'd6;

	// move timing constants
	localparam int DUR_MIN_MS   = 120;
	localparam int DUR_MAX_MS   = 3000;
	localparam int FALLBACK_DPS = 60;
	localparam int MIN_DPS      = 5;
	localparam int DEF_SPD_MIN  = 500;
	localparam int PULSE_MID_US = 1500;
	localparam int PERIOD_US    = 20000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TGT,
		ST_DMUL,
		ST_DDIV,
		ST_TCHK,
		ST_TDIV,
		ST_T2,
		ST_E,
		ST_BY,
		ST_BP,
		ST_PN,
		ST_PC,
		ST_PD,
		ST_OUT
	} state_t;

endpackage

### hdl/sspt_in_if.sv
`timescale 1ns / 1ps
// Input channel: valid/ready with one set-target or tick item.
// Depends on sspt_pkg for field widths.
interface sspt_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  mode;
	logic signed [sspt_pkg::ANGLE_W-1:0]   yaw_target;
	logic signed [sspt_pkg::ANGLE_W-1:0]   pitch_target;
	logic        [sspt_pkg::SPEED_W-1:0]   speed_dps;
	logic        [sspt_pkg::TIME_W-1:0]    now_ms;

	modport source(output valid, mode, yaw_target, pitch_target, speed_dps, now_ms,
		input ready);
	modport sink(input valid, mode, yaw_target, pitch_target, speed_dps, now_ms,
		output ready);
endinterface

### hdl/sspt_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready with duty words and blended angles.
// Depends on sspt_pkg for field widths.
interface sspt_out_if #(parameter int DUTY_BITS = sspt_pkg::DUTY_BITS_DEF);
	logic                                valid;
	logic                                ready;
	logic        [DUTY_BITS-1:0]         yaw_duty;
	logic        [DUTY_BITS-1:0]         pitch_duty;
	logic signed [sspt_pkg::ANGLE_W-1:0] yaw_position;
	logic signed [sspt_pkg::ANGLE_W-1:0] pitch_position;
	logic                                still_moving;

	modport source(output valid, yaw_duty, pitch_duty, yaw_position, pitch_position,
		still_moving, input ready);
	modport sink(input valid, yaw_duty, pitch_duty, yaw_position, pitch_position,
		still_moving, output ready);
endinterface

### hdl/servo_smoothstep_pwm_trajectory.sv
`timescale 1ns / 1ps
// Two-axis smoothstep servo trajectory generator with PWM duty output.
// Depends on sspt_pkg, sspt_in_if and sspt_out_if.
//
// Usage:
//   item   : valid/ready input. mode 0 sets a new target (clamped to the yaw and
//            pitch limits) and starts a move from the current position; mode 1
//            is a time tick that yields one result while a move runs.
//   result : valid/ready output with both duty words, blended angles and
//            still_moving (low on the final step of a move).
//   cfg_*  : register write port, index 0..6, taken whenever cfg_we is high.
// Sequencing: one item at a time, item.ready is high only when the sequencer is
//   idle. A set target runs a 17-step shift-add multiply then a 32-step
//   restoring divide for the move time. A tick runs a 16-step divide for t,
//   four 17-step multiplies (t^2, ease curve, two axis blends) and two
//   DUTY_BITS-step divides for the duty words on one shared multiplier and
//   divider; the final tick of a move goes straight to the duty divides. An idle tick gives no result.
// The result sits in an output register; the block works on the next item
//   while it waits and only holds in its last step if the register is full.
// Reset: clears the position, goal and move state to zero and loads the
//   register defaults; no result is pending.
module servo_smoothstep_pwm_trajectory #(
	parameter int ANGLE_FRAC_BITS = sspt_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int DUTY_BITS       = sspt_pkg::DUTY_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	sspt_in_if.sink                          item,
	sspt_out_if.source                       result,
	input  logic                             cfg_we,
	input  logic [sspt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sspt_pkg::CFG_W-1:0]       cfg_data
);

	localparam int AW       = sspt_pkg::ANGLE_W;
	localparam int DEN      = 90 << ANGLE_FRAC_BITS;
	localparam int DUTY_DEN = DEN * sspt_pkg::PERIOD_US;
	localparam int MID_NUM  = sspt_pkg::PULSE_MID_US * DEN;
	localparam int DVW      = $clog2(DUTY_DEN + 1);
	localparam int NW       = DVW + 1;
	localparam int MAW      = 18;
	localparam int MBW      = 17;
	localparam int PW       = MAW + MBW;
	localparam int QW       = 32;

	// ---------------- registers ----------------
	sspt_pkg::state_t state_q, state_d;

	logic signed [AW-1:0] yaw_lo_q, yaw_hi_q, pitch_lo_q, pitch_hi_q;
	logic [11:0] dspd_q, pmin_q, pmax_q;

	logic [sspt_pkg::TIME_W-1:0] now_q;
	logic [sspt_pkg::SPEED_W-1:0] speed_q;

	logic signed [AW-1:0] cur_yaw_q, cur_pitch_q, start_yaw_q, start_pitch_q;
	logic signed [AW-1:0] goal_yaw_q, goal_pitch_q;
	logic [31:0] move_start_q;
	logic [11:0] move_dur_q;
	logic moving_q;

	logic [DVW-1:0] spd_dvs_q;
	logic [15:0] t_q;
	logic [16:0] e_q;
	logic axis_q;
	logic signed [NW-1:0] num_q;
	logic [DVW-1:0] lo_q, hi_q;
	logic [DUTY_BITS-1:0] duty_yaw_q;

	logic out_valid_q, out_moving_q;
	logic [DUTY_BITS-1:0] out_yduty_q, out_pduty_q;
	logic signed [AW-1:0] out_ypos_q, out_ppos_q;

	// serial multiplier
	logic [PW-1:0] mul_acc_q, mul_a_q;
	logic [MBW-1:0] mul_b_q;
	logic [4:0] mul_cnt_q;
	logic mul_busy_q;
	logic mul_start;
	logic [MAW-1:0] mul_a;
	logic [MBW-1:0] mul_b;

	// serial divider
	logic [DVW-1:0] div_rem_q, div_dvs_q;
	logic [QW-1:0] div_quo_q;
	logic [5:0] div_cnt_q;
	logic div_busy_q;
	logic div_start;
	logic [DVW-1:0] div_rem, div_dvs;
	logic [QW-1:0] div_quo;
	logic [5:0] div_n;

	function automatic logic signed [AW-1:0] clamp_ang(logic signed [AW-1:0] v,
		logic signed [AW-1:0] lo, logic signed [AW-1:0] hi);
		logic signed [AW-1:0] r;
		r = v;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

	function automatic logic [AW:0] abs_diff(logic signed [AW-1:0] a,
		logic signed [AW-1:0] b);
		logic signed [AW:0] d;
		d = {a[AW-1], a} - {b[AW-1], b};
		return d[AW] ? -d : d;
	endfunction

	// ---------------- handshake ----------------
	logic in_xfer, out_xfer, out_free;
	assign item.ready = (state_q == sspt_pkg::ST_IDLE);
	assign in_xfer    = item.valid && item.ready;
	assign out_xfer   = out_valid_q && result.ready;
	assign out_free   = !out_valid_q || result.ready;

	assign result.valid          = out_valid_q;
	assign result.yaw_duty       = out_yduty_q;
	assign result.pitch_duty     = out_pduty_q;
	assign result.yaw_position   = out_ypos_q;
	assign result.pitch_position = out_ppos_q;
	assign result.still_moving   = out_moving_q;

	// ---------------- combinational datapath ----------------
	// move time setup
	localparam int SPEED_W_L = sspt_pkg::SPEED_W;
	logic [AW:0] ang_span;
	logic [15:0] s15;
	logic [SPEED_W_L-1:0] dps_unused;
	logic [16:0] k_sel;
	logic [DVW-1:0] dvs_sel;
	always_comb begin
		ang_span = abs_diff(goal_yaw_q, cur_yaw_q) + abs_diff(goal_pitch_q, cur_pitch_q);
		s15  = {dspd_q, 4'b0} - {4'b0, dspd_q};
		dps_unused = (speed_q > SPEED_W_L'(sspt_pkg::MIN_DPS)) ? speed_q
			: SPEED_W_L'(sspt_pkg::FALLBACK_DPS);
		if (speed_q != '0) begin
			k_sel   = 17'd1000;
			dvs_sel = DVW'(dps_unused) << ANGLE_FRAC_BITS;
		end else if (s15 > 16'(sspt_pkg::DEF_SPD_MIN)) begin
			k_sel   = 17'd100000;
			dvs_sel = DVW'(s15) << ANGLE_FRAC_BITS;
		end else begin
			k_sel   = 17'd1000;
			dvs_sel = DVW'(sspt_pkg::FALLBACK_DPS) << ANGLE_FRAC_BITS;
		end
	end

	// tick: elapsed time and end of move
	logic [31:0] elapsed;
	logic tick_done;
	assign elapsed   = now_q - move_start_q;
	assign tick_done = (move_dur_q == '0) || (elapsed >= {20'b0, move_dur_q});

	// blend deltas
	logic signed [AW:0] dy, dp;
	logic [AW:0] dy_mag, dp_mag, part;
	logic signed [AW:0] blend_y, blend_p;
	always_comb begin
		dy = {goal_yaw_q[AW-1], goal_yaw_q} - {start_yaw_q[AW-1], start_yaw_q};
		dp = {goal_pitch_q[AW-1], goal_pitch_q} - {start_pitch_q[AW-1], start_pitch_q};
		dy_mag = dy[AW] ? -dy : dy;
		dp_mag = dp[AW] ? -dp : dp;
		part   = mul_acc_q[AW+16:16];
		blend_y = {start_yaw_q[AW-1], start_yaw_q} + (dy[AW] ? -part : part);
		blend_p = {start_pitch_q[AW-1], start_pitch_q} + (dp[AW] ? -part : part);
	end

	// duration clamp
	logic [11:0] dur_clamped;
	always_comb begin
		if (div_quo_q < QW'(sspt_pkg::DUR_MIN_MS))
			dur_clamped = 12'(sspt_pkg::DUR_MIN_MS);
		else if (div_quo_q > QW'(sspt_pkg::DUR_MAX_MS))
			dur_clamped = 12'(sspt_pkg::DUR_MAX_MS);
		else
			dur_clamped = div_quo_q[11:0];
	end

	// pulse numerator and limits
	logic signed [AW-1:0] pos_sel;
	logic signed [NW-1:0] pos_ext, num_d, num_cl;
	always_comb begin
		pos_sel = axis_q ? cur_pitch_q : cur_yaw_q;
		pos_ext = {{(NW-AW){pos_sel[AW-1]}}, pos_sel};
		num_d   = $signed(NW'(MID_NUM)) + pos_ext * $signed(NW'(1000));
		num_cl  = num_q;
		if (num_cl < $signed({1'b0, lo_q})) num_cl = $signed({1'b0, lo_q});
		if (num_cl > $signed({1'b0, hi_q})) num_cl = $signed({1'b0, hi_q});
		if (num_cl < 0) num_cl = '0;
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			sspt_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (!item.mode) state_d = sspt_pkg::ST_TGT;
					else if (moving_q) state_d = sspt_pkg::ST_TCHK;
				end
			end
			sspt_pkg::ST_TGT:  state_d = sspt_pkg::ST_DMUL;
			sspt_pkg::ST_DMUL: if (!mul_busy_q) state_d = sspt_pkg::ST_DDIV;
			sspt_pkg::ST_DDIV: if (!div_busy_q) state_d = sspt_pkg::ST_IDLE;
			sspt_pkg::ST_TCHK: state_d = tick_done ? sspt_pkg::ST_PN : sspt_pkg::ST_TDIV;
			sspt_pkg::ST_TDIV: if (!div_busy_q) state_d = sspt_pkg::ST_T2;
			sspt_pkg::ST_T2:   if (!mul_busy_q) state_d = sspt_pkg::ST_E;
			sspt_pkg::ST_E:    if (!mul_busy_q) state_d = sspt_pkg::ST_BY;
			sspt_pkg::ST_BY:   if (!mul_busy_q) state_d = sspt_pkg::ST_BP;
			sspt_pkg::ST_BP:   if (!mul_busy_q) state_d = sspt_pkg::ST_PN;
			sspt_pkg::ST_PN:   state_d = sspt_pkg::ST_PC;
			sspt_pkg::ST_PC:   state_d = sspt_pkg::ST_PD;
			sspt_pkg::ST_PD: begin
				if (!div_busy_q) state_d = axis_q ? sspt_pkg::ST_OUT : sspt_pkg::ST_PN;
			end
			sspt_pkg::ST_OUT:  if (out_free) state_d = sspt_pkg::ST_IDLE;
			default:           state_d = sspt_pkg::ST_IDLE;
		endcase
	end

	// ---------------- unit start strobes ----------------
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_rem   = '0;
		div_quo   = '0;
		div_dvs   = '0;
		div_n     = '0;
		case (state_q)
			sspt_pkg::ST_TGT: begin
				mul_start = 1'b1;
				mul_a     = MAW'(ang_span);
				mul_b     = k_sel;
			end
			sspt_pkg::ST_DMUL: begin
				div_start = !mul_busy_q;
				div_quo   = mul_acc_q[QW-1:0];
				div_dvs   = spd_dvs_q;
				div_n     = 6'(QW);
			end
			sspt_pkg::ST_TCHK: begin
				div_start = !tick_done;
				div_rem   = DVW'(elapsed[11:0]);
				div_dvs   = DVW'(move_dur_q);
				div_n     = 6'd16;
			end
			sspt_pkg::ST_TDIV: begin
				mul_start = !div_busy_q;
				mul_a     = MAW'(div_quo_q[15:0]);
				mul_b     = MBW'(div_quo_q[15:0]);
			end
			sspt_pkg::ST_T2: begin
				mul_start = !mul_busy_q;
				mul_a     = MAW'(196608) - {1'b0, t_q, 1'b0};
				mul_b     = MBW'(mul_acc_q[31:16]);
			end
			sspt_pkg::ST_E: begin
				mul_start = !mul_busy_q;
				mul_a     = MAW'(dy_mag);
				mul_b     = mul_acc_q[32:16];
			end
			sspt_pkg::ST_BY: begin
				mul_start = !mul_busy_q;
				mul_a     = MAW'(dp_mag);
				mul_b     = e_q;
			end
			sspt_pkg::ST_PC: begin
				div_start = 1'b1;
				div_rem   = num_cl[DVW-1:0];
				div_dvs   = DVW'(DUTY_DEN);
				div_n     = 6'(DUTY_BITS);
			end
			default: ;
		endcase
	end

	// ---------------- sequencer and state registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= sspt_pkg::ST_IDLE;
			cur_yaw_q     <= '0;
			cur_pitch_q   <= '0;
			start_yaw_q   <= '0;
			start_pitch_q <= '0;
			goal_yaw_q    <= '0;
			goal_pitch_q  <= '0;
			move_start_q  <= '0;
			move_dur_q    <= '0;
			moving_q      <= 1'b0;
			axis_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				sspt_pkg::ST_IDLE: begin
					if (in_xfer) begin
						now_q   <= item.now_ms;
						speed_q <= item.speed_dps;
						if (!item.mode) begin
							goal_yaw_q   <= clamp_ang(item.yaw_target, yaw_lo_q, yaw_hi_q);
							goal_pitch_q <= clamp_ang(item.pitch_target, pitch_lo_q,
								pitch_hi_q);
						end
					end
				end
				sspt_pkg::ST_TGT: spd_dvs_q <= dvs_sel;
				sspt_pkg::ST_DDIV: begin
					if (!div_busy_q) begin
						move_dur_q    <= dur_clamped;
						move_start_q  <= now_q;
						start_yaw_q   <= cur_yaw_q;
						start_pitch_q <= cur_pitch_q;
						moving_q      <= 1'b1;
					end
				end
				sspt_pkg::ST_TCHK: begin
					axis_q <= 1'b0;
					if (tick_done) begin
						cur_yaw_q   <= goal_yaw_q;
						cur_pitch_q <= goal_pitch_q;
						moving_q    <= 1'b0;
					end
				end
				sspt_pkg::ST_TDIV: if (!div_busy_q) t_q <= div_quo_q[15:0];
				sspt_pkg::ST_E:    if (!mul_busy_q) e_q <= mul_acc_q[32:16];
				sspt_pkg::ST_BY:   if (!mul_busy_q) cur_yaw_q <= blend_y[AW-1:0];
				sspt_pkg::ST_BP:   if (!mul_busy_q) cur_pitch_q <= blend_p[AW-1:0];
				sspt_pkg::ST_PN: begin
					num_q <= num_d;
					lo_q  <= DVW'(pmin_q) * DVW'(DEN);
					hi_q  <= DVW'(pmax_q) * DVW'(DEN);
				end
				sspt_pkg::ST_PD: begin
					if (!div_busy_q && !axis_q) begin
						duty_yaw_q <= div_quo_q[DUTY_BITS-1:0];
						axis_q     <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == sspt_pkg::ST_OUT && out_free) begin
			out_valid_q  <= 1'b1;
			out_yduty_q  <= duty_yaw_q;
			out_pduty_q  <= div_quo_q[DUTY_BITS-1:0];
			out_ypos_q   <= cur_yaw_q;
			out_ppos_q   <= cur_pitch_q;
			out_moving_q <= moving_q;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	// ---------------- configuration registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_lo_q   <= -13'sd1440;
			yaw_hi_q   <= 13'sd1440;
			pitch_lo_q <= -13'sd480;
			pitch_hi_q <= 13'sd480;
			dspd_q     <= 12'd300;
			pmin_q     <= 12'd500;
			pmax_q     <= 12'd2500;
		end else if (cfg_we) begin
			case (cfg_index)
				sspt_pkg::CFG_YAW_LO:    yaw_lo_q   <= cfg_data[AW-1:0];
				sspt_pkg::CFG_YAW_HI:    yaw_hi_q   <= cfg_data[AW-1:0];
				sspt_pkg::CFG_PITCH_LO:  pitch_lo_q <= cfg_data[AW-1:0];
				sspt_pkg::CFG_PITCH_HI:  pitch_hi_q <= cfg_data[AW-1:0];
				sspt_pkg::CFG_DEF_SPEED: dspd_q     <= cfg_data[11:0];
				sspt_pkg::CFG_PULSE_MIN: pmin_q     <= cfg_data[11:0];
				sspt_pkg::CFG_PULSE_MAX: pmax_q     <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// ---------------- bit-serial shift-add multiplier ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_cnt_q  <= '0;
		end else if (mul_start) begin
			mul_acc_q  <= '0;
			mul_a_q    <= PW'(mul_a);
			mul_b_q    <= mul_b;
			mul_cnt_q  <= 5'(MBW);
			mul_busy_q <= 1'b1;
		end else if (mul_busy_q) begin
			if (mul_b_q[0]) mul_acc_q <= mul_acc_q + mul_a_q;
			mul_a_q   <= mul_a_q << 1;
			mul_b_q   <= mul_b_q >> 1;
			mul_cnt_q <= mul_cnt_q - 5'd1;
			if (mul_cnt_q == 5'd1) mul_busy_q <= 1'b0;
		end
	end

	// ---------------- bit-serial restoring divider ----------------
	logic [DVW:0] div_trial;
	assign div_trial = {div_rem_q, div_quo_q[QW-1]} - {1'b0, div_dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (div_start) begin
			div_rem_q  <= div_rem;
			div_quo_q  <= div_quo;
			div_dvs_q  <= div_dvs;
			div_cnt_q  <= div_n;
			div_busy_q <= 1'b1;
		end else if (div_busy_q) begin
			if (div_trial[DVW])
				div_rem_q <= {div_rem_q[DVW-2:0], div_quo_q[QW-1]};
			else
				div_rem_q <= div_trial[DVW-1:0];
			div_quo_q <= {div_quo_q[QW-2:0], ~div_trial[DVW]};
			div_cnt_q <= div_cnt_q - 6'd1;
			if (div_cnt_q == 6'd1) div_busy_q <= 1'b0;
		end
	end

endmodule

### sim/servo_smoothstep_pwm_trajectory_tb.sv
`timescale 1ns / 1ps
// Testbench for servo_smoothstep_pwm_trajectory: drives set-target and tick items,
// predicts each duty/position result in place and checks them as they arrive.
// Depends on sspt_pkg, sspt_in_if, sspt_out_if and the block itself.
module servo_smoothstep_pwm_trajectory_tb;

	localparam int FRAC      = sspt_pkg::ANGLE_FRAC_BITS_DEF;
	localparam int DBITS     = sspt_pkg::DUTY_BITS_DEF;
	localparam int AW        = sspt_pkg::ANGLE_W;
	localparam int CW        = sspt_pkg::CFG_W;
	localparam int IW        = sspt_pkg::CFG_IDX_W;
	localparam int LIMIT     = 3000000;
	localparam int IDLE_WAIT = 200;
	localparam int N_RANDOM  = 1100;
	localparam logic MODE_TARGET = 1'b0;
	localparam logic MODE_TICK   = 1'b1;
	localparam logic [IW-1:0] CFG_UNUSED = 3'd7;

	typedef struct {
		logic [DBITS-1:0]     yaw_duty;
		logic [DBITS-1:0]     pitch_duty;
		logic signed [AW-1:0] yaw_pos;
		logic signed [AW-1:0] pitch_pos;
		logic                 moving;
	} servo_frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IW-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;

	sspt_in_if item_ch();
	sspt_out_if #(.DUTY_BITS(DBITS)) frame_ch();

	servo_smoothstep_pwm_trajectory DUT (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(frame_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// predictor state: registers and trajectory
	logic [CW-1:0] shadow_cfg [0:6];
	int          cur_yaw, cur_pitch, from_yaw, from_pitch, goal_yaw, goal_pitch;
	logic [31:0] move_t0;
	longint      move_len;
	bit          in_motion;

	servo_frame_t frame_q[$];
	int  errors = 0;
	int  items_sent = 0;
	int  frames_seen = 0;
	int  cycles = 0;
	bit  gaps_on = 1'b0;
	int  rx_hold_req = 0;
	int  rx_hold_left = 0;

	function automatic int sx13(logic [CW-1:0] v);
		return int'($signed(v));
	endfunction

	function automatic int clamp_lohi(int v, int lo, int hi);
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return v;
	endfunction

	function automatic logic [DBITS-1:0] duty_word(int pos);
		longint den, num, lo, hi;
		den = 64'd90 << FRAC;
		num = 1500 * den + longint'(pos) * 1000;
		lo = longint'(shadow_cfg[sspt_pkg::CFG_PULSE_MIN][11:0]) * den;
		hi = longint'(shadow_cfg[sspt_pkg::CFG_PULSE_MAX][11:0]) * den;
		if (num < lo) num = lo;
		if (num > hi) num = hi;
		if (num < 0) num = 0;
		return DBITS'((num << DBITS) / (den * sspt_pkg::PERIOD_US));
	endfunction

	function automatic int ease_toward(int a, int b, longint e);
		return int'(longint'(a) + (longint'(b - a) * e) / 65536);
	endfunction

	// advance the trajectory for one accepted item
	task automatic predict_item(logic mode, int yt, int pt, int spd, logic [31:0] now);
		longint span, dur, s, dps, t, t2, e;
		logic [31:0] el;
		servo_frame_t f;
		if (mode == MODE_TARGET) begin
			goal_yaw = clamp_lohi(yt, sx13(shadow_cfg[sspt_pkg::CFG_YAW_LO]),
				sx13(shadow_cfg[sspt_pkg::CFG_YAW_HI]));
			goal_pitch = clamp_lohi(pt, sx13(shadow_cfg[sspt_pkg::CFG_PITCH_LO]),
				sx13(shadow_cfg[sspt_pkg::CFG_PITCH_HI]));
			span = (goal_yaw > cur_yaw ? goal_yaw - cur_yaw : cur_yaw - goal_yaw)
				+ (goal_pitch > cur_pitch ? goal_pitch - cur_pitch : cur_pitch - goal_pitch);
			if (spd > 0) begin
				dps = spd > sspt_pkg::MIN_DPS ? spd : sspt_pkg::FALLBACK_DPS;
				dur = span * 1000 / (dps << FRAC);
			end else begin
				s = shadow_cfg[sspt_pkg::CFG_DEF_SPEED][11:0];
				if (s * 15 > sspt_pkg::DEF_SPD_MIN) dur = span * 100000 / ((s * 15) << FRAC);
				else dur = span * 1000 / (sspt_pkg::FALLBACK_DPS << FRAC);
			end
			if (dur < sspt_pkg::DUR_MIN_MS) dur = sspt_pkg::DUR_MIN_MS;
			if (dur > sspt_pkg::DUR_MAX_MS) dur = sspt_pkg::DUR_MAX_MS;
			move_len = dur;
			move_t0 = now;
			from_yaw = cur_yaw;
			from_pitch = cur_pitch;
			in_motion = 1'b1;
			return;
		end
		if (!in_motion) return;
		el = now - move_t0;
		if (move_len == 0 || longint'(el) >= move_len) begin
			cur_yaw = goal_yaw;
			cur_pitch = goal_pitch;
			in_motion = 1'b0;
		end else begin
			t = (longint'(el) << 16) / move_len;
			t2 = (t * t) >>> 16;
			e = (t2 * (196608 - 2 * t)) >>> 16;
			cur_yaw = ease_toward(from_yaw, goal_yaw, e);
			cur_pitch = ease_toward(from_pitch, goal_pitch, e);
		end
		f.yaw_duty = duty_word(cur_yaw);
		f.pitch_duty = duty_word(cur_pitch);
		f.yaw_pos = AW'(cur_yaw);
		f.pitch_pos = AW'(cur_pitch);
		f.moving = in_motion;
		frame_q.push_back(f);
	endtask

	function automatic int pick_gap();
		int r;
		if (!gaps_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// offer one item and wait for its transfer
	task automatic send_item(logic mode, int yt, int pt, int spd, logic [31:0] now);
		int gap;
		gap = pick_gap();
		repeat (gap) @(negedge clk) item_ch.valid <= 1'b0;
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.mode <= mode;
		item_ch.yaw_target <= AW'(yt);
		item_ch.pitch_target <= AW'(pt);
		item_ch.speed_dps <= sspt_pkg::SPEED_W'(spd);
		item_ch.now_ms <= now;
		do @(posedge clk); while (!item_ch.ready);
		predict_item(mode, yt, pt, spd, now);
		items_sent++;
	endtask

	task automatic idle_input();
		@(negedge clk) item_ch.valid <= 1'b0;
	endtask

	// wait until every predicted frame is out and the sequencer has settled
	task automatic drain();
		idle_input();
		while (frame_q.size() > 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic cfg_write(logic [IW-1:0] idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CW'(val);
		@(negedge clk) cfg_we <= 1'b0;
		if (idx <= sspt_pkg::CFG_PULSE_MAX)
			shadow_cfg[idx] = idx <= sspt_pkg::CFG_PITCH_HI ? CW'(val) : CW'(val & 12'hFFF);
	endtask

	task automatic cfg_all(int ylo, int yhi, int plo, int phi, int ds, int pmin, int pmax);
		cfg_write(sspt_pkg::CFG_YAW_LO, ylo);
		cfg_write(sspt_pkg::CFG_YAW_HI, yhi);
		cfg_write(sspt_pkg::CFG_PITCH_LO, plo);
		cfg_write(sspt_pkg::CFG_PITCH_HI, phi);
		cfg_write(sspt_pkg::CFG_DEF_SPEED, ds);
		cfg_write(sspt_pkg::CFG_PULSE_MIN, pmin);
		cfg_write(sspt_pkg::CFG_PULSE_MAX, pmax);
	endtask

	// tick through the running move until its final step
	task automatic follow_move(logic [31:0] t0, bit zero_first);
		logic [31:0] el;
		int n, step;
		el = 0;
		n = 0;
		if (zero_first) send_item(MODE_TICK, 0, 0, 0, t0);
		while (in_motion && n < 30) begin
			step = $urandom_range(1, int'(move_len) / 6 + 1);
			if ($urandom_range(0, 9) == 0) step = $urandom_range(1, 3);
			el += step;
			send_item(MODE_TICK, $urandom_range(0, 8191), $urandom_range(0, 8191),
				$urandom_range(0, 1023), t0 + el);
			n++;
		end
		if (in_motion) send_item(MODE_TICK, 0, 0, 0, t0 + 32'(move_len) + $urandom_range(0, 50));
	endtask

	function automatic int rand_angle();
		return $urandom_range(0, 5760) - 2880;
	endfunction

	function automatic int rand_speed();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) return 0;
		if (r < 4) return $urandom_range(1, 5);
		return $urandom_range(6, 1000);
	endfunction

	// defaults: extremes of the fields, the explicit, low-speed and default-speed rules, idle and mid-move cases
	task automatic test_directed();
		send_item(MODE_TICK, 0, 0, 0, 32'd5);
		send_item(MODE_TARGET, 2880, -2880, 1000, 32'd100);
		follow_move(32'd100, 1'b1);
		send_item(MODE_TARGET, -2880, 2880, 0, 32'hFFFF_FF00);
		follow_move(32'hFFFF_FF00, 1'b0);
		send_item(MODE_TARGET, 100, 50, 3, 32'd7);
		send_item(MODE_TICK, 0, 0, 0, 32'd300);
		send_item(MODE_TARGET, 1440, 480, 5, 32'd301);
		send_item(MODE_TICK, 0, 0, 0, 32'd302);
		send_item(MODE_TICK, 0, 0, 0, 32'hFFFF_FFFF);
		send_item(MODE_TARGET, 0, 0, 6, 32'hFFFF_FFFF);
		follow_move(32'hFFFF_FFFF, 1'b0);
		send_item(MODE_TICK, 4095, -4096, 1023, 32'h8000_0000);
		drain();
	endtask

	// extreme and inverted register settings, plus a write to an unused index
	task automatic test_config_extremes();
		cfg_all(-2880, 2880, -2880, 2880, 0, 500, 2500);
		cfg_write(CFG_UNUSED, 8191);
		send_item(MODE_TARGET, -2880, -2880, 0, 32'd1000);
		follow_move(32'd1000, 1'b1);
		send_item(MODE_TARGET, 2880, 2880, 0, 32'd9000);
		follow_move(32'd9000, 1'b0);
		drain();
		cfg_all(1000, -1000, 300, -300, 3000, 2500, 500);
		send_item(MODE_TARGET, 2000, -2000, 0, 32'd50);
		follow_move(32'd50, 1'b0);
		drain();
		cfg_all(-1440, 1440, -480, 480, 34, 1200, 1700);
		send_item(MODE_TARGET, 1440, -480, 0, 32'd70);
		follow_move(32'd70, 1'b0);
		drain();
	endtask

	// receiver holds off while ticks keep coming, then the sender waits for all
	task automatic test_backpressure();
		int k;
		gaps_on = 1'b0;
		send_item(MODE_TARGET, -1400, 400, 0, 32'd0);
		rx_hold_req = 1500;
		for (k = 1; k <= 12; k++) send_item(MODE_TICK, 0, 0, 0, 32'(k * 40));
		drain();
	endtask

	task automatic test_random();
		int ph, goal_items;
		logic [31:0] t0;
		goal_items = items_sent + N_RANDOM;
		ph = 0;
		while (items_sent < goal_items) begin
			if (items_sent >= goal_items - N_RANDOM + ph * (N_RANDOM / 5)) begin
				drain();
				if (ph == 4) cfg_all(-1440, 1440, -480, 480, 300, 500, 2500);
				else cfg_all(-$urandom_range(0, 2880), $urandom_range(0, 2880),
					rand_angle(), rand_angle(), $urandom_range(0, 3000),
					$urandom_range(500, 1400), $urandom_range(1300, 2500));
				gaps_on = $urandom_range(0, 3) != 0;
				ph++;
			end
			t0 = $urandom();
			case ($urandom_range(0, 9))
				0: send_item(MODE_TICK, rand_angle(), rand_angle(), rand_speed(), t0);
				1: begin
					send_item(MODE_TARGET, rand_angle(), rand_angle(), rand_speed(), t0);
					send_item(MODE_TICK, 0, 0, 0, t0 + $urandom_range(0, 100));
					send_item(MODE_TARGET, rand_angle(), rand_angle(), rand_speed(), t0 + 200);
					follow_move(t0 + 200, 1'b0);
				end
				default: begin
					send_item(MODE_TARGET, rand_angle(), rand_angle(), rand_speed(), t0);
					follow_move(t0, $urandom_range(0, 3) == 0);
				end
			endcase
		end
		drain();
	endtask

	// receiver: random ready, occasional long hold-offs counted here
	always @(negedge clk) begin
		int r;
		if (rx_hold_req > 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			frame_ch.ready <= 1'b0;
		end else if (!gaps_on) begin
			frame_ch.ready <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3) rx_hold_left = $urandom_range(20, 80);
			frame_ch.ready <= r >= 25;
		end
	end

	// compare each frame transfer with the oldest prediction
	always @(posedge clk) begin
		servo_frame_t w;
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			frames_seen++;
			if (frame_q.size() == 0) begin
				errors++;
				$display("%t unexpected frame yaw_duty=%0d pitch_duty=%0d", $time,
					frame_ch.yaw_duty, frame_ch.pitch_duty);
			end else begin
				w = frame_q.pop_front();
				if (frame_ch.yaw_duty !== w.yaw_duty || frame_ch.pitch_duty !== w.pitch_duty
					|| frame_ch.yaw_position !== w.yaw_pos
					|| frame_ch.pitch_position !== w.pitch_pos
					|| frame_ch.still_moving !== w.moving) begin
					errors++;
					$display("%t mismatch exp duty %0d/%0d pos %0d/%0d mv %0d", $time,
						w.yaw_duty, w.pitch_duty, w.yaw_pos, w.pitch_pos, w.moving);
					$display("%t          got duty %0d/%0d pos %0d/%0d mv %0d", $time,
						frame_ch.yaw_duty, frame_ch.pitch_duty, frame_ch.yaw_position,
						frame_ch.pitch_position, frame_ch.still_moving);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_TICK;
		item_ch.yaw_target = '0;
		item_ch.pitch_target = '0;
		item_ch.speed_dps = '0;
		item_ch.now_ms = '0;
		frame_ch.ready = 1'b0;
		shadow_cfg[sspt_pkg::CFG_YAW_LO] = CW'(-1440);
		shadow_cfg[sspt_pkg::CFG_YAW_HI] = CW'(1440);
		shadow_cfg[sspt_pkg::CFG_PITCH_LO] = CW'(-480);
		shadow_cfg[sspt_pkg::CFG_PITCH_HI] = CW'(480);
		shadow_cfg[sspt_pkg::CFG_DEF_SPEED] = CW'(300);
		shadow_cfg[sspt_pkg::CFG_PULSE_MIN] = CW'(500);
		shadow_cfg[sspt_pkg::CFG_PULSE_MAX] = CW'(2500);
		cur_yaw = 0; cur_pitch = 0; from_yaw = 0; from_pitch = 0;
		goal_yaw = 0; goal_pitch = 0; move_t0 = 0; move_len = 0; in_motion = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		gaps_on = 1'b1;
		test_config_extremes();
		test_backpressure();
		test_random();
		$display("Run: %0d items, %0d frames checked over reset, extreme, inverted and random",
			items_sent, frames_seen);
		$display("register settings, with long result hold-offs and random gaps.");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/sspt_pkg.sv
hdl/sspt_in_if.sv
hdl/sspt_out_if.sv
hdl/servo_smoothstep_pwm_trajectory.sv
sim/servo_smoothstep_pwm_trajectory_tb.sv
